@@ rtl/qda_pkg.sv @@
package qda_pkg;

    localparam int TIME_W = 16;
    localparam int CFG_W  = 16;
    localparam int CIDX_W = 2;
    localparam int DIV_W  = 16;
    localparam int DIVR_W = 8;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    // operation codes
    localparam logic [1:0] OP_SEED = 2'd0;
    localparam logic [1:0] OP_EDGE = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_SLOW  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_FAST  = 2'd1;
    localparam logic [CIDX_W-1:0] CFG_DECAY = 2'd2;
    localparam logic [CIDX_W-1:0] CFG_MAXM  = 2'd3;

    // register reset values, and the cap on the multiplier
    localparam logic [7:0]        SLOW_RST  = 8'd25;
    localparam logic [7:0]        FAST_RST  = 8'd3;
    localparam logic [TIME_W-1:0] DECAY_RST = 16'd100;
    localparam logic [3:0]        MAXM_RST  = 4'd4;
    localparam logic [3:0]        MAXM_CAP  = 4'd8;

    // direction codes, two's complement of the step
    localparam logic [1:0] DIR_NONE = 2'b00;
    localparam logic [1:0] DIR_POS  = 2'b01;
    localparam logic [1:0] DIR_NEG  = 2'b11;

    typedef struct packed {
        logic [TIME_W-1:0] stamp;
        logic [1:0]        dir;
    } hist_entry_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             busy;
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/qda_hist.sv @@
module qda_hist #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] wr_addr,
    input  qda_pkg::hist_entry_t             wr_entry,
    input  logic [$clog2(HISTORY_DEPTH)-1:0] rd_addr,
    output qda_pkg::hist_entry_t             rd_entry
);
    import qda_pkg::*;

    hist_entry_t mem [HISTORY_DEPTH];
    hist_entry_t rd_entry_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_entry_reg <= mem[rd_addr];
    end

    assign rd_entry = rd_entry_reg;

endmodule

@@ rtl/qda_div.sv @@
module qda_div (
    input  logic              clk,
    input  logic              rst_n,
    input  qda_pkg::div_req_t req,
    output qda_pkg::div_rsp_t rsp
);
    import qda_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  dvd_reg, dvd_next;
    logic [DIVR_W-1:0] rem_reg, rem_next;
    logic [DIVR_W-1:0] dsr_reg, dsr_next;
    logic [DIVR_W:0]   rem_sh;
    logic [DIVR_W:0]   diff;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        rem_sh    = {rem_reg, dvd_reg[DIV_W-1]};
        diff      = rem_sh - {1'b0, dsr_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CW'(DIV_W);
            dvd_next  = req.dividend;
            rem_next  = '0;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVR_W])
            begin
                rem_next = diff[DIVR_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIVR_W-1:0];
                dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

@@ rtl/quadrature_decoder_with_acceleration.sv @@
// seed and edge items leave the block idle; the block takes the next item in the following cycle
// a read reaches S_OUT, which raises result_valid, directly for a zero quotient or short history,
// through S_NEW and S_AGE for a stale history, on through a scan of the ring and S_DECIDE for a
// disagreeing majority, and on through one pass of the shared 16-step divider or two (mean, multiplier);
// a full, stalled output slot holds the block until the result is posted
// asynchronous active-low reset loads default registers and empties phase, count and history
module quadrature_decoder_with_acceleration #(
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [qda_pkg::CIDX_W-1:0]           cfg_index,
    input  logic [qda_pkg::CFG_W-1:0]            cfg_data,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [1:0]                           operation,
    input  logic                                 pin_a,
    input  logic                                 pin_b,
    input  logic [qda_pkg::TIME_W-1:0]           now_ms,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [7:0]                    detent_count
);
    import qda_pkg::*;

    localparam int HW = $clog2(HISTORY_DEPTH);
    localparam int FW = $clog2(HISTORY_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_NEW    = 3'd1;
    localparam logic [2:0] S_AGE    = 3'd2;
    localparam logic [2:0] S_SCAN   = 3'd3;
    localparam logic [2:0] S_DECIDE = 3'd4;
    localparam logic [2:0] S_DIV1   = 3'd5;
    localparam logic [2:0] S_DIV2   = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    logic [2:0]        state_reg, state_next;
    logic [7:0]        slow_reg, fast_reg;
    logic [TIME_W-1:0] decay_reg;
    logic [3:0]        maxm_reg;
    logic [1:0]        phase_reg, phase_next;
    logic signed [7:0] acc_reg, acc_next;
    logic [1:0]        prev_reg, prev_next;
    logic [HW-1:0]     head_reg, head_next;
    logic [FW-1:0]     fill_reg, fill_next;
    logic signed [6:0] q_reg, q_next;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [TIME_W-1:0] newest_reg, newest_next;
    logic [TIME_W-1:0] oldest_reg, oldest_next;
    logic [HW-1:0]     idx_reg, idx_next;
    logic [FW-1:0]     iss_reg, iss_next;
    logic [FW-1:0]     pos_reg, pos_next;
    logic [FW-1:0]     neg_reg, neg_next;
    logic [3:0]        mx_reg, mx_next;
    logic [7:0]        res_reg, res_next;
    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;

    logic              accept;
    logic [1:0]        new_phase;
    logic [1:0]        d;
    logic [1:0]        step_dir;
    logic              reversal;
    logic signed [7:0] acc_base;
    logic [FW-1:0]     fill_base;
    logic [7:0]        mag;
    logic signed [6:0] qmag;
    logic signed [6:0] q_calc;
    logic signed [7:0] rem_calc;
    logic [HW-1:0]     newest_idx;
    logic [HW-1:0]     tail_idx;
    logic [FW:0]       oldest_tmp;
    logic [TIME_W-1:0] age;
    logic [7:0]        diff_slow;
    logic [10:0]       mul_num;

    logic              wr_en;
    hist_entry_t       wr_entry;
    logic [HW-1:0]     rd_addr;
    hist_entry_t       rd_entry;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    function automatic logic [HW-1:0] idx_inc(input logic [HW-1:0] i);
        idx_inc = (i == HW'(HISTORY_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [7:0] sat_mul(input logic signed [6:0] q, input logic [3:0] m);
        logic signed [11:0] p;
        p = q * $signed({1'b0, m});
        if (p > 12'sd127)
            sat_mul = 8'h7f;
        else if (p < -12'sd128)
            sat_mul = 8'h80;
        else
            sat_mul = p[7:0];
    endfunction

    qda_hist #(
        .HISTORY_DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .clk      (clk),
        .wr_en    (wr_en),
        .wr_addr  (head_reg),
        .wr_entry (wr_entry),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry)
    );

    qda_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign accept     = item_valid && !item_stall;
    assign item_stall = (state_reg != S_IDLE);

    // phase code: {a, a ^ b}
    assign new_phase = {pin_a, pin_a ^ pin_b};
    assign d         = phase_reg - new_phase;
    assign step_dir  = d[1] ? DIR_POS : DIR_NEG;
    assign reversal  = (prev_reg != DIR_NONE) && (prev_reg != step_dir);
    assign acc_base  = (reversal && (acc_reg > -8'sd4) && (acc_reg < 8'sd4)) ? 8'sd0 : acc_reg;
    assign fill_base = reversal ? '0 : fill_reg;

    // divide by four toward zero; full negative count has magnitude 128
    assign mag      = acc_reg[7] ? 8'(-acc_reg) : acc_reg;
    assign qmag     = {1'b0, mag[7:2]};
    assign q_calc   = acc_reg[7] ? -qmag : qmag;
    assign rem_calc = acc_reg[7] ? -$signed({6'b0, mag[1:0]}) : $signed({6'b0, mag[1:0]});

    assign newest_idx = (head_reg == '0) ? HW'(HISTORY_DEPTH - 1) : head_reg - 1'b1;
    assign oldest_tmp = (FW+1)'(head_reg) + (FW+1)'(HISTORY_DEPTH) - {1'b0, fill_reg};
    assign tail_idx   = (oldest_tmp >= (FW+1)'(HISTORY_DEPTH))
                        ? HW'(oldest_tmp - (FW+1)'(HISTORY_DEPTH)) : HW'(oldest_tmp);

    assign age       = now_reg - rd_entry.stamp;
    assign diff_slow = slow_reg - div_rsp.quotient[7:0];
    assign mul_num   = 11'(mx_reg - 4'd1) * 11'(diff_slow);

    assign wr_en          = accept && (operation == OP_EDGE) && d[0];
    assign wr_entry.stamp = now_ms;
    assign wr_entry.dir   = step_dir;

    always_comb
    begin
        case (state_reg)
            S_NEW:   rd_addr = newest_idx;
            S_AGE:   rd_addr = tail_idx;
            default: rd_addr = idx_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        prev_next      = prev_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        q_next         = q_reg;
        now_next       = now_reg;
        newest_next    = newest_reg;
        oldest_next    = oldest_reg;
        idx_next       = idx_reg;
        iss_next       = iss_reg;
        pos_next       = pos_reg;
        neg_next       = neg_reg;
        mx_next        = mx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && result_stall;
        out_data_next  = out_data_reg;
        div_req.start    = 1'b0;
        div_req.dividend = newest_reg - oldest_reg;
        div_req.divisor  = DIVR_W'(fill_reg - 1'b1);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OP_SEED:
                        begin
                            phase_next = new_phase;
                            acc_next   = '0;
                            prev_next  = DIR_NONE;
                            head_next  = '0;
                            fill_next  = '0;
                        end
                        OP_EDGE:
                        begin
                            if (d[0])
                            begin
                                phase_next = new_phase;
                                prev_next  = step_dir;
                                acc_next   = acc_base + (d[1] ? 8'sd1 : -8'sd1);
                                head_next  = idx_inc(head_reg);
                                fill_next  = (fill_base < FW'(HISTORY_DEPTH))
                                             ? fill_base + 1'b1 : fill_base;
                            end
                        end
                        OP_READ:
                        begin
                            acc_next = rem_calc;
                            q_next   = q_calc;
                            now_next = now_ms;
                            res_next = {q_calc[6], q_calc};
                            if (q_calc == 7'sd0 || fill_reg < FW'(2))
                                state_next = S_OUT;
                            else
                                state_next = S_NEW;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_NEW:
            begin
                state_next = S_AGE;
            end
            S_AGE:
            begin
                if (age > decay_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    newest_next = rd_entry.stamp;
                    idx_next    = idx_inc(tail_idx);
                    iss_next    = FW'(1);
                    pos_next    = '0;
                    neg_next    = '0;
                    state_next  = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // entry issued last cycle arrives now; first one is the oldest
                if (iss_reg == FW'(1))
                    oldest_next = rd_entry.stamp;
                if (rd_entry.dir == DIR_POS)
                    pos_next = pos_reg + 1'b1;
                else if (rd_entry.dir == DIR_NEG)
                    neg_next = neg_reg + 1'b1;
                if (iss_reg < fill_reg)
                begin
                    idx_next = idx_inc(idx_reg);
                    iss_next = iss_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (((pos_reg > neg_reg) && q_reg[6]) || ((neg_reg > pos_reg) && !q_reg[6]))
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    if (maxm_reg == 4'd0)
                        mx_next = 4'd1;
                    else if (maxm_reg > MAXM_CAP)
                        mx_next = MAXM_CAP;
                    else
                        mx_next = maxm_reg;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient >= DIV_W'(slow_reg))
                    begin
                        state_next = S_OUT;
                    end
                    else if (div_rsp.quotient <= DIV_W'(fast_reg))
                    begin
                        res_next   = sat_mul(q_reg, mx_reg);
                        state_next = S_OUT;
                    end
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = DIV_W'(mul_num);
                        div_req.divisor  = slow_reg - fast_reg;
                        state_next       = S_DIV2;
                    end
                end
            end
            S_DIV2:
            begin
                if (div_rsp.done)
                begin
                    res_next   = sat_mul(q_reg, div_rsp.quotient[3:0] + 4'd1);
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            slow_reg      <= SLOW_RST;
            fast_reg      <= FAST_RST;
            decay_reg     <= DECAY_RST;
            maxm_reg      <= MAXM_RST;
            phase_reg     <= '0;
            acc_reg       <= '0;
            prev_reg      <= DIR_NONE;
            head_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            prev_reg      <= prev_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLOW:  slow_reg  <= cfg_data[7:0];
                    CFG_FAST:  fast_reg  <= cfg_data[7:0];
                    CFG_DECAY: decay_reg <= cfg_data;
                    CFG_MAXM:  maxm_reg  <= cfg_data[3:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg        <= q_next;
        now_reg      <= now_next;
        newest_reg   <= newest_next;
        oldest_reg   <= oldest_next;
        idx_reg      <= idx_next;
        iss_reg      <= iss_next;
        pos_reg      <= pos_next;
        neg_reg      <= neg_next;
        mx_reg       <= mx_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign result_valid = out_valid_reg;
    assign detent_count = out_data_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(HISTORY_DEPTH))
        else $error("history fill above depth");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (fill_reg >= FW'(2) && iss_reg != '0 && iss_reg <= fill_reg))
        else $error("history scan out of range");

    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && result_stall) |=> (state_reg == S_OUT))
        else $error("result dropped while output slot full");

endmodule

@@ sim/quadrature_decoder_with_acceleration_tb.sv @@
module quadrature_decoder_with_acceleration_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import qda_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DEPTH = 8;
    localparam int READ_SETTLE = 64;

    logic clk;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CIDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic [1:0] operation = OP_SEED;
    logic pin_a = 1'b0;
    logic pin_b = 1'b0;
    logic [TIME_W-1:0] now_ms = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [7:0] detent_count;

    quadrature_decoder_with_acceleration dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .item_valid(item_valid),
        .item_stall(item_stall),
        .operation(operation),
        .pin_a(pin_a),
        .pin_b(pin_b),
        .now_ms(now_ms),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .detent_count(detent_count)
    );

    // decoder state as predicted by the testbench
    logic [1:0] m_phase;
    logic signed [7:0] m_count;
    logic [1:0] m_last_dir;
    logic [15:0] m_stamp [DEPTH];
    logic [1:0] m_dir [DEPTH];
    int m_head;
    int m_fill;
    logic [7:0] m_slow;
    logic [7:0] m_fast;
    logic [15:0] m_decay;
    logic [3:0] m_maxm;

    logic signed [7:0] pending_detents [$];
    int mismatch_count = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_span = 0;
    logic [15:0] knob_ms = '0;
    logic signed [7:0] want_detents;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void model_seed(logic [1:0] ph, logic [15:0] t);
        m_phase = ph;
        m_count = '0;
        m_last_dir = DIR_NONE;
        for (int i = 0; i < DEPTH; i++)
        begin
            m_stamp[i] = t;
            m_dir[i] = DIR_NONE;
        end
        m_head = 0;
        m_fill = 0;
    endfunction

    function automatic void model_reset();
        m_slow = SLOW_RST;
        m_fast = FAST_RST;
        m_decay = DECAY_RST;
        m_maxm = MAXM_RST;
        model_seed(2'd0, 16'd0);
    endfunction

    function automatic void model_edge(logic [1:0] ph, logic [15:0] t);
        logic [1:0] d;
        logic [1:0] dir;
        d = m_phase - ph;
        // even distance: no movement or a skipped state
        if (!d[0])
            return;
        m_phase = ph;
        dir = d[1] ? DIR_POS : DIR_NEG;
        if (m_last_dir != DIR_NONE && dir != m_last_dir)
        begin
            if (m_count > -4 && m_count < 4)
                m_count = '0;
            m_fill = 0;
        end
        m_last_dir = dir;
        m_count = (dir == DIR_POS) ? m_count + 8'sd1 : m_count - 8'sd1;
        m_stamp[m_head] = t;
        m_dir[m_head] = dir;
        m_head = (m_head + 1) % DEPTH;
        if (m_fill < DEPTH)
            m_fill++;
    endfunction

    function automatic logic signed [7:0] detents_for_read(logic [15:0] t);
        int v, q, pos_n, neg_n, maj, mean, mx, mult, r, newest, oldest, idx;
        logic [15:0] age, span;
        v = m_count;
        q = v / 4;
        m_count = 8'(v % 4);
        if (q == 0)
            return 8'sd0;
        newest = (m_head + DEPTH - 1) % DEPTH;
        age = t - m_stamp[newest];
        if (age > m_decay || m_fill < 2)
            return 8'(q);
        oldest = (m_head + DEPTH - m_fill) % DEPTH;
        pos_n = 0;
        neg_n = 0;
        idx = oldest;
        for (int i = 0; i < m_fill; i++)
        begin
            if (m_dir[idx] == DIR_POS)
                pos_n++;
            else if (m_dir[idx] == DIR_NEG)
                neg_n++;
            idx = (idx + 1) % DEPTH;
        end
        maj = (pos_n > neg_n) ? 1 : (neg_n > pos_n) ? -1 : 0;
        if (maj != 0 && maj != ((q > 0) ? 1 : -1))
            return 8'(q);
        span = m_stamp[newest] - m_stamp[oldest];
        mean = int'(span) / (m_fill - 1);
        mx = int'(m_maxm);
        if (mx < 1)
            mx = 1;
        if (mx > 8)
            mx = 8;
        if (mean >= int'(m_slow))
            mult = 1;
        else if (mean <= int'(m_fast))
            mult = mx;
        else
            mult = 1 + ((mx - 1) * (int'(m_slow) - mean)) / (int'(m_slow) - int'(m_fast));
        r = q * mult;
        if (r > 127)
            r = 127;
        if (r < -128)
            r = -128;
        return 8'(r);
    endfunction

    function automatic void apply_item(logic [1:0] op, logic a, logic b, logic [15:0] t);
        logic [1:0] ph;
        ph = {a, a ^ b};
        case (op)
            OP_SEED: model_seed(ph, t);
            OP_EDGE: model_edge(ph, t);
            OP_READ: pending_detents.push_back(detents_for_read(t));
            default: ;
        endcase
    endfunction

    task automatic send_item(logic [1:0] op, logic a, logic b, logic [15:0] t);
        int gap;
        operation <= op;
        pin_a <= a;
        pin_b <= b;
        now_ms <= t;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        apply_item(op, a, b, t);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                    : $urandom_range(1, 8);
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // one detent-quarter step of the knob; dir is +1 or -1
    task automatic knob_step(int dir, int dt);
        logic [1:0] ph;
        knob_ms = knob_ms + 16'(dt);
        ph = m_phase + 2'(dir);
        send_item(OP_EDGE, ph[1], ph[1] ^ ph[0], knob_ms);
    endtask

    task automatic read_at(int delay);
        knob_ms = knob_ms + 16'(delay);
        send_item(OP_READ, $urandom_range(0, 1), $urandom_range(0, 1), knob_ms);
    endtask

    task automatic drain_results();
        item_valid <= 1'b0;
        while (pending_detents.size() != 0)
            @(posedge clk);
        repeat (READ_SETTLE) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_settings(int slow, int fast, int decay, int maxm);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= CFG_SLOW;
        cfg_data <= {8'($urandom), 8'(slow)};
        @(posedge clk);
        cfg_index <= CFG_FAST;
        cfg_data <= {8'($urandom), 8'(fast)};
        @(posedge clk);
        cfg_index <= CFG_DECAY;
        cfg_data <= 16'(decay);
        @(posedge clk);
        cfg_index <= CFG_MAXM;
        cfg_data <= {12'($urandom), 4'(maxm)};
        @(posedge clk);
        cfg_we <= 1'b0;
        m_slow = 8'(slow);
        m_fast = 8'(fast);
        m_decay = 16'(decay);
        m_maxm = 4'(maxm);
    endtask

    // runs of knob motion with reads in between, plus some noise
    task automatic spin_mix(int n);
        int sent, pick, run_len, dir, base_dt, read_every, k;
        sent = 0;
        dir = 1;
        while (sent < n)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
            begin
                knob_ms = 16'($urandom);
                send_item(OP_SEED, $urandom_range(0, 1), $urandom_range(0, 1), knob_ms);
                sent++;
            end
            else if (pick < 12)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        knob_ms = knob_ms + 16'($urandom_range(0, 50));
                        send_item(OP_EDGE, $urandom_range(0, 1), $urandom_range(0, 1), knob_ms);
                    end
                    1: send_item(OP_UNUSED, $urandom_range(0, 1), $urandom_range(0, 1),
                                 16'($urandom));
                    2: read_at($urandom_range(0, 65535));
                    default: read_at(0);
                endcase
                sent++;
            end
            else
            begin
                if ($urandom_range(0, 2) == 0)
                    dir = -dir;
                case ($urandom_range(0, 3))
                    0: base_dt = $urandom_range(0, 4);
                    1: base_dt = $urandom_range(3, 15);
                    2: base_dt = $urandom_range(10, 60);
                    default: base_dt = $urandom_range(40, 300);
                endcase
                if ($urandom_range(0, 11) == 0)
                begin
                    // long spin: wraps the count or saturates the scaled result
                    run_len = $urandom_range(40, 140);
                    read_every = $urandom_range(0, 1) ? 0 : $urandom_range(60, 80);
                end
                else
                begin
                    run_len = $urandom_range(1, 12);
                    read_every = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
                for (k = 1; k <= run_len; k++)
                begin
                    knob_step(dir, base_dt + $urandom_range(0, base_dt / 4 + 1));
                    sent++;
                    if (read_every != 0 && k % read_every == 0)
                    begin
                        read_at($urandom_range(0, 3));
                        sent++;
                    end
                end
                if ($urandom_range(0, 1))
                begin
                    read_at(($urandom_range(0, 9) == 0) ? $urandom_range(50, 400)
                                                       : $urandom_range(0, 4));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_special_cases();
        read_at(0);
        send_item(OP_UNUSED, 1'b1, 1'b1, 16'hFFFF);
        knob_ms = 16'd65530;
        send_item(OP_SEED, 1'b1, 1'b1, knob_ms);
        // same phase, then a skipped state: both ignored
        send_item(OP_EDGE, 1'b1, 1'b1, knob_ms);
        send_item(OP_EDGE, 1'b0, 1'b0, knob_ms);
        // fast spin across the tick wrap
        repeat (5) knob_step(1, 2);
        read_at(1);
        // reversal, then a mid-range interval
        repeat (5) knob_step(-1, 10);
        read_at(1);
        // reversal with a large count keeps it but empties the history
        repeat (4) knob_step(-1, 10);
        knob_step(1, 10);
        read_at(1);
        repeat (4) knob_step(1, 5);
        read_at(500);
    endtask

    task automatic test_default_mix();
        spin_mix(380);
    endtask

    task automatic test_count_extremes();
        write_settings(255, 0, 65535, 8);
        knob_ms = 16'h0100;
        send_item(OP_SEED, 1'b0, 1'b0, knob_ms);
        // full turn of the count to its most negative value
        repeat (128) knob_step(1, 1);
        read_at(0);
        repeat (80) knob_step(1, 1);
        read_at(0);
        repeat (80) knob_step(-1, 0);
        read_at(0);
        spin_mix(150);
    endtask

    task automatic test_no_acceleration();
        write_settings(1, 0, 0, 1);
        spin_mix(220);
    endtask

    task automatic test_inverted_window();
        write_settings(6, 20, 40, 15);
        spin_mix(260);
    endtask

    task automatic test_zero_multiplier();
        write_settings(40, 10, 300, 0);
        spin_mix(220);
    endtask

    task automatic test_random_settings();
        int slow, fast;
        repeat (2)
        begin
            slow = $urandom_range(2, 255);
            fast = $urandom_range(0, slow - 1);
            write_settings(slow, fast,
                           $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 65535),
                           $urandom_range(1, 15));
            spin_mix(130);
        end
    endtask

    // result check and receiver stall pattern
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_detents.size() == 0)
            begin
                $display("%0t: unexpected detent_count, expected none, actual %0d",
                         $time, detent_count);
                mismatch_count++;
            end
            else
            begin
                want_detents = pending_detents.pop_front();
                if (detent_count !== want_detents)
                begin
                    $display("%0t: detent_count mismatch, expected %0d, actual %0d",
                             $time, want_detents, detent_count);
                    mismatch_count++;
                end
            end
        end
        if (stall_span <= 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_span = $urandom_range(10, 300);
        end
        stall_span--;
        case (stall_mode)
            0: result_stall <= 1'b0;
            1: result_stall <= ($urandom_range(0, 3) == 0);
            2: result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= ((stall_span % 16) < 10);
        endcase
    end

    initial
    begin
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_default_mix();
        test_count_extremes();
        test_no_acceleration();
        test_inverted_window();
        test_zero_multiplier();
        test_random_settings();
        drain_results();
        if (mismatch_count == 0)
            $display("[quadrature_decoder_with_acceleration] OK");
        else
            $display("[quadrature_decoder_with_acceleration] ERROR");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout with %0d results outstanding", pending_detents.size());
        $display("[quadrature_decoder_with_acceleration] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/qda_pkg.sv
rtl/qda_hist.sv
rtl/qda_div.sv
rtl/quadrature_decoder_with_acceleration.sv
sim/quadrature_decoder_with_acceleration_tb.sv
